@@ rtl/pcm_sample_format_converter_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the format converter RTL.
// ---------------------------------------------------------------------------
`ifndef PCM_SAMPLE_FORMAT_CONVERTER_DEFINES_SVH
`define PCM_SAMPLE_FORMAT_CONVERTER_DEFINES_SVH

// The condition must never be true at a clock edge outside reset.
`define PCMFC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define PCMFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pcmfc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmfc_pkg
// Types and constants shared by the PCM format converter modules.
// ---------------------------------------------------------------------------
package pcmfc_pkg;

    // Largest group size for downsampling.
    localparam int MAX_SCALE = 16;

    // Group sums: 17-bit samples times at most 16 frames, signed.
    localparam int SUM_W = 22;
    localparam int CNT_W = 5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_IN_SIGNED    = 3'd0;
    localparam logic [2:0] CFG_IN_DELTA     = 3'd1;
    localparam logic [2:0] CFG_IN_STEREO    = 3'd2;
    localparam logic [2:0] CFG_OUT_SIGNED   = 3'd3;
    localparam logic [2:0] CFG_OUT_DELTA    = 3'd4;
    localparam logic [2:0] CFG_OUT_STEREO   = 3'd5;
    localparam logic [2:0] CFG_OUT_8BIT     = 3'd6;
    localparam logic [2:0] CFG_SCALE_FACTOR = 3'd7;

    typedef struct packed {
        logic [15:0] sample_first;
        logic [15:0] sample_second;
        logic        end_of_sample;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_sample;
        logic        out_channel;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic       in_signed;
        logic       in_delta;
        logic       in_stereo;
        logic       out_signed;
        logic       out_delta;
        logic       out_stereo;
        logic       out_8bit;
        logic [4:0] scale_factor;
    } cfg_t;

    // Work handed from the front end to the back end.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum0;
        logic signed [SUM_W-1:0] sum1;
        logic [CNT_W-1:0]        cnt;
        logic                    emit;
        logic                    eos;
    } job_t;

endpackage

@@ rtl/pcm_sample_format_converter.sv @@
`timescale 1ns / 1ps
// A frame that completes a group is queued; the back end pops it, divides the sums
// by the frame count, four quotient bits per step, and emits the result (the right
// channel after the left when the output is stereo); it pops no new group before that.
// Frames that complete no group are taken one per cycle while the queue is not full.
// Reset: asynchronous, active low; state is reset, queued job and result data are not.
// ---------------------------------------------------------------------------
// pcm_sample_format_converter
// PCM format conversion with downsampling and error-feedback dither.
// ---------------------------------------------------------------------------
module pcm_sample_format_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [4:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pcmfc_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pcmfc_pkg::out_item_t out_data
);
    import pcmfc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;
    job_t q_job;
    job_t q_head;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IN_SIGNED:    cfg_next.in_signed    = cfg_data[0];
                CFG_IN_DELTA:     cfg_next.in_delta     = cfg_data[0];
                CFG_IN_STEREO:    cfg_next.in_stereo    = cfg_data[0];
                CFG_OUT_SIGNED:   cfg_next.out_signed   = cfg_data[0];
                CFG_OUT_DELTA:    cfg_next.out_delta    = cfg_data[0];
                CFG_OUT_STEREO:   cfg_next.out_stereo   = cfg_data[0];
                CFG_OUT_8BIT:     cfg_next.out_8bit     = cfg_data[0];
                CFG_SCALE_FACTOR: cfg_next.scale_factor = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_signed    <= 1'b1;
            cfg_reg.in_delta     <= 1'b0;
            cfg_reg.in_stereo    <= 1'b0;
            cfg_reg.out_signed   <= 1'b1;
            cfg_reg.out_delta    <= 1'b0;
            cfg_reg.out_stereo   <= 1'b0;
            cfg_reg.out_8bit     <= 1'b0;
            cfg_reg.scale_factor <= 5'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pcmfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    pcmfc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    pcmfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/pcmfc_fifo.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmfc_fifo
// Two-entry queue of jobs between the front end and the back end.
// ---------------------------------------------------------------------------
`include "pcm_sample_format_converter_defines.svh"
module pcmfc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcmfc_pkg::job_t push_job,
    input  logic            pop,
    output pcmfc_pkg::job_t head,
    output logic            empty,
    output logic            full
);
    import pcmfc_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `PCMFC_ASSERT_NEVER(a_no_push_full, push && full && !pop, "push into full queue")
    `PCMFC_ASSERT_NEVER(a_no_pop_empty, pop && empty, "pop from empty queue")
    `PCMFC_ASSERT_NEVER(a_count_range, count_reg == 2'd3, "queue count out of range")

endmodule

@@ rtl/pcmfc_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmfc_front
// Accepts frames, decodes delta and sign, converts channels and groups frames.
// ---------------------------------------------------------------------------
module pcmfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  pcmfc_pkg::cfg_t     cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  pcmfc_pkg::in_item_t in_data,
    input  logic                q_full,
    output logic                q_push,
    output pcmfc_pkg::job_t     q_job
);
    import pcmfc_pkg::*;

    logic [15:0]             acc_reg;
    logic [15:0]             acc_next;
    logic signed [SUM_W-1:0] sum0_reg;
    logic signed [SUM_W-1:0] sum0_next;
    logic signed [SUM_W-1:0] sum1_reg;
    logic signed [SUM_W-1:0] sum1_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;

    logic                    accept;
    logic [15:0]             acc1;
    logic [15:0]             acc2;
    logic [15:0]             a_bits;
    logic [15:0]             b_bits;
    logic signed [16:0]      va;
    logic signed [16:0]      vb;
    logic signed [17:0]      pair_sum;
    logic signed [17:0]      pair_adj;
    logic signed [16:0]      va_ch;
    logic signed [16:0]      vb_ch;
    logic signed [SUM_W-1:0] sum0_add;
    logic signed [SUM_W-1:0] sum1_add;
    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        scale;
    logic                    emit;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // Delta decoding with one accumulator, left before right.
    always_comb
    begin
        acc1   = acc_reg + in_data.sample_first;
        acc2   = acc1 + in_data.sample_second;
        a_bits = cfg.in_delta ? acc1 : in_data.sample_first;
        b_bits = (cfg.in_delta && cfg.in_stereo) ? acc2 : in_data.sample_second;
        if (cfg.in_signed != cfg.out_signed)
        begin
            a_bits[15] = ~a_bits[15];
            b_bits[15] = ~b_bits[15];
        end
    end

    // Read the samples in the output signedness and convert channels.
    always_comb
    begin
        va       = cfg.out_signed ? {a_bits[15], a_bits} : {1'b0, a_bits};
        vb       = cfg.out_signed ? {b_bits[15], b_bits} : {1'b0, b_bits};
        pair_sum = 18'(va) + 18'(vb);
        pair_adj = pair_sum + (pair_sum[17] ? 18'sd1 : 18'sd0);
        va_ch    = va;
        vb_ch    = va;
        if (cfg.in_stereo)
        begin
            vb_ch = vb;
            if (!cfg.out_stereo)
            begin
                va_ch = 17'(pair_adj >>> 1);
            end
        end
    end

    // Group accumulation and the decision to emit.
    always_comb
    begin
        sum0_add = sum0_reg + SUM_W'(va_ch);
        sum1_add = sum1_reg + SUM_W'(vb_ch);
        cnt_inc  = cnt_reg + 5'd1;
        if (cfg.scale_factor == 5'd0)
        begin
            scale = 5'd1;
        end
        else if (int'(cfg.scale_factor) > MAX_SCALE)
        begin
            scale = 5'(MAX_SCALE);
        end
        else
        begin
            scale = cfg.scale_factor;
        end
        emit = (cnt_inc >= scale) || in_data.end_of_sample;

        q_push     = accept && emit;
        q_job.sum0 = sum0_add;
        q_job.sum1 = sum1_add;
        q_job.cnt  = cnt_inc;
        q_job.emit = 1'b1;
        q_job.eos  = in_data.end_of_sample;

        acc_next  = acc_reg;
        sum0_next = sum0_reg;
        sum1_next = sum1_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            if (cfg.in_delta)
            begin
                acc_next = cfg.in_stereo ? acc2 : acc1;
            end
            if (emit)
            begin
                sum0_next = '0;
                sum1_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                sum0_next = sum0_add;
                sum1_next = sum1_add;
                cnt_next  = cnt_inc;
            end
            if (in_data.end_of_sample)
            begin
                acc_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            sum0_reg <= '0;
            sum1_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            sum0_reg <= sum0_next;
            sum1_reg <= sum1_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ rtl/pcmfc_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcmfc_back
// Averages groups with a shared divider, optionally delta encodes and dithers to 8 bits.
// ---------------------------------------------------------------------------
`include "pcm_sample_format_converter_defines.svh"
module pcmfc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcmfc_pkg::cfg_t      cfg,
    input  logic                 q_empty,
    input  pcmfc_pkg::job_t      q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pcmfc_pkg::out_item_t out_data
);
    import pcmfc_pkg::*;

    localparam int DIV_BITS  = 4;
    localparam int MAG_W     = ((SUM_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS = MAG_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    job_t               job_reg;
    job_t               job_next;
    logic               ch_reg;
    logic               ch_next;
    logic [MAG_W-1:0]   dq_reg;
    logic [MAG_W-1:0]   dq_next;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   rem_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               neg_reg;
    logic               neg_next;
    logic [15:0]        prev_reg;
    logic [15:0]        prev_next;
    logic signed [9:0]  err_reg;
    logic signed [9:0]  err_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;

    logic [CNT_W:0]     r;
    logic [MAG_W-1:0]   d;
    logic signed [17:0] q18;
    logic signed [17:0] v;
    logic [15:0]        diff;
    logic signed [17:0] vd;
    logic signed [17:0] eep;
    logic [15:0]        clamped;
    logic [15:0]        sample;
    logic [9:0]         err_calc;
    logic               load;
    logic               more;
    logic               div_last;
    logic signed [SUM_W-1:0] start_sum;
    logic [SUM_W-1:0]   start_mag;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign div_last  = (state_reg == S_DIV) && (step_reg == STEP_W'(DIV_STEPS - 1));

    // Several quotient bits per cycle of the restoring divider.
    always_comb
    begin
        r = '0;
        d = dq_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r = {(i == 0) ? rem_reg : r[CNT_W-1:0], d[MAG_W-1]};
            d = {d[MAG_W-2:0], 1'b0};
            if (r >= {1'b0, job_reg.cnt})
            begin
                r    = r - {1'b0, job_reg.cnt};
                d[0] = 1'b1;
            end
        end
    end

    // Delta encoding, then clamping and error-feedback dither for 8-bit output.
    always_comb
    begin
        q18  = $signed(dq_reg[17:0]);
        v    = neg_reg ? -q18 : q18;
        diff = v[15:0] - prev_reg;
        vd   = v;
        if (cfg.out_delta)
        begin
            vd = cfg.out_signed ? {{2{diff[15]}}, diff} : {2'b00, diff};
        end
        eep = vd + 18'(err_reg);
        if (cfg.out_signed)
        begin
            if (eep < -32768)
            begin
                clamped = 16'h8000;
            end
            else if (eep > 32767)
            begin
                clamped = 16'h7FFF;
            end
            else
            begin
                clamped = eep[15:0];
            end
        end
        else
        begin
            if (eep < 0)
            begin
                clamped = 16'h0000;
            end
            else if (eep > 65535)
            begin
                clamped = 16'hFFFF;
            end
            else
            begin
                clamped = eep[15:0];
            end
        end
        err_calc = {2'b00, eep[7:0]} - err_reg;
        sample   = cfg.out_8bit ? {8'h00, clamped[15:8]} : vd[15:0];
    end

    // Sequencer over the jobs of the queue.
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        ch_next        = ch_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        prev_next      = prev_reg;
        err_next       = err_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        load           = 1'b0;
        more           = cfg.out_stereo && !ch_reg;
        start_sum      = job_reg.sum1;
        start_mag      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    job_next  = q_head;
                    ch_next   = 1'b0;
                    start_sum = q_head.sum0;
                    start_mag = start_sum[SUM_W-1] ? SUM_W'(-start_sum) : start_sum;
                    dq_next   = MAG_W'(start_mag);
                    rem_next  = '0;
                    step_next = '0;
                    neg_next  = start_sum[SUM_W-1];
                    if (q_head.emit)
                    begin
                        state_next = S_DIV;
                    end
                    else if (q_head.eos)
                    begin
                        prev_next = '0;
                        err_next  = 10'sd32;
                    end
                end
            end
            S_DIV:
            begin
                dq_next   = d;
                rem_next  = r[CNT_W-1:0];
                step_next = step_reg + 1'b1;
                if (div_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load                      = 1'b1;
                    out_data_next.out_sample  = sample;
                    out_data_next.out_channel = ch_reg;
                    out_data_next.last_of_run = !more;
                    if (cfg.out_delta)
                    begin
                        prev_next = v[15:0];
                    end
                    if (cfg.out_8bit)
                    begin
                        err_next = $signed(err_calc);
                    end
                    if (more)
                    begin
                        ch_next    = 1'b1;
                        start_sum  = job_reg.sum1;
                        start_mag  = start_sum[SUM_W-1] ? SUM_W'(-start_sum) : start_sum;
                        dq_next    = MAG_W'(start_mag);
                        rem_next   = '0;
                        step_next  = '0;
                        neg_next   = start_sum[SUM_W-1];
                        state_next = S_DIV;
                    end
                    else
                    begin
                        if (job_reg.eos)
                        begin
                            prev_next = '0;
                            err_next  = 10'sd32;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= 1'b0;
            step_reg      <= '0;
            prev_reg      <= '0;
            err_reg       <= 10'sd32;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            step_reg      <= step_next;
            prev_reg      <= prev_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    `PCMFC_ASSERT_NEVER(a_no_overwrite, load && out_valid_reg && !out_ready, "result overwritten")
    `PCMFC_ASSERT_NEVER(a_pop_idle_only, q_pop && (state_reg != S_IDLE), "pop while busy")
    `PCMFC_ASSERT_NEXT(a_div_to_emit, div_last, state_reg == S_EMIT, "divider did not finish")

endmodule
